FILE: src/bcrp_pkg.sv
// bcrp_pkg: shared types, constants and helpers for the bend corner relief block
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package bcrp_pkg;
	localparam int COORD_FRAC_BITS = 16;
	localparam int UNIT_FRAC = 30;
	localparam logic [63:0] MATCH_LIMIT = (64'd1 << (2 * COORD_FRAC_BITS)) / 64'd10000;
	localparam logic [63:0] SHORT_LIMIT = (64'd1 << (2 * COORD_FRAC_BITS)) / 64'd1000000;
	localparam logic [31:0] DIAG_Q32 = 32'd3037000500;
	localparam logic [63:0] BOUND = 64'd1 << COORD_FRAC_BITS;

	// direction unit depth: normalize and square stages, then root and divide steps
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 32;
	localparam int UNIT_LATENCY = 2 + SQRT_STEPS + DIV_STEPS;

	typedef enum logic [0:0] {
		CFG_MODE   = 1'b0,
		CFG_RADIUS = 1'b1
	} cfg_idx_t;

	typedef enum logic [0:0] {
		MODE_OCTAGON = 1'b0,
		MODE_DOGBONE = 1'b1
	} relief_mode_t;

	typedef struct packed {
		logic        valid;
		logic        hit;
		logic [1:0]  sel;
	} match_t;

	// unit direction result handed to the vertex stage
	typedef struct packed {
		logic               ok;
		logic signed [32:0] ux;
		logic signed [32:0] uy;
	} unit_t;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		mag33 = v[32] ? 33'(-v) : 33'(v);
	endfunction

	// true when |dx|,|dy| below bound and the squared length within limit
	function automatic logic small_sq(input logic signed [32:0] dx,
		input logic signed [32:0] dy, input logic [63:0] limit);
		logic [32:0] ax, ay;
		logic [63:0] s;
		ax = mag33(dx);
		ay = mag33(dy);
		s = 64'(ax[COORD_FRAC_BITS-1:0]) * 64'(ax[COORD_FRAC_BITS-1:0])
			+ 64'(ay[COORD_FRAC_BITS-1:0]) * 64'(ay[COORD_FRAC_BITS-1:0]);
		small_sq = (64'(ax) < BOUND) && (64'(ay) < BOUND) && (s <= limit);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647)
			sat32 = 32'h7fffffff;
		else if (v < -35'sd2147483648)
			sat32 = 32'h80000000;
		else
			sat32 = v[31:0];
	endfunction
endpackage
`default_nettype wire

FILE: src/bcrp_lane.sv
// bcrp_lane: one endpoint-pair lane, tests a pair for a shared corner
// depends on bcrp_pkg
`timescale 1ns / 1ps
`default_nettype none
module bcrp_lane import bcrp_pkg::*; (
	input  wire logic               clk,
	input  wire logic signed [31:0] p_x,
	input  wire logic signed [31:0] p_y,
	input  wire logic signed [31:0] q_x,
	input  wire logic signed [31:0] q_y,
	output logic                    hit_s1
);
	logic signed [32:0] dx, dy;
	assign dx = 33'(p_x) - 33'(q_x);
	assign dy = 33'(p_y) - 33'(q_y);
	always_ff @(posedge clk) begin
		hit_s1 <= small_sq(dx, dy, MATCH_LIMIT);
	end
endmodule
`default_nettype wire

FILE: src/bcrp_unit.sv
// bcrp_unit: pipelined unit direction (normalize, bit-serial sqrt, two dividers)
// depends on bcrp_pkg; one stage per result bit, a new vector every cycle
`timescale 1ns / 1ps
`default_nettype none
module bcrp_unit import bcrp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic signed [32:0] dx,
	input  wire logic signed [32:0] dy,
	output logic                    out_valid,
	output unit_t                   out_u
);
	localparam int SQ = SQRT_STEPS;
	localparam int DV = DIV_STEPS;

	// normalize stage
	logic [32:0] ax, ay, m, nx, ny;
	logic [5:0] lz;
	always_comb begin
		ax = mag33(dx);
		ay = mag33(dy);
		m = (ax > ay) ? ax : ay;
		lz = 6'd0;
		nx = ax;
		ny = ay;
		if (m[32]) begin
			nx = ax >> 2; ny = ay >> 2;
		end else if (m[31]) begin
			nx = ax >> 1; ny = ay >> 1;
		end else begin
			for (int i = 0; i <= 30; i++)
				if (m[i]) lz = 6'(30 - i);
			nx = ax << lz;
			ny = ay << lz;
		end
	end

	logic v_s1, ok_s1, sx_s1, sy_s1;
	logic [30:0] nx_s1, ny_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		ok_s1 <= !small_sq(dx, dy, SHORT_LIMIT);
		sx_s1 <= dx[32];
		sy_s1 <= dy[32];
		nx_s1 <= nx[30:0];
		ny_s1 <= ny[30:0];
	end

	// squaring stage
	logic v_s2, ok_s2, sx_s2, sy_s2;
	logic [30:0] nx_s2, ny_s2;
	logic [63:0] n_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		ok_s2 <= ok_s1; sx_s2 <= sx_s1; sy_s2 <= sy_s1;
		nx_s2 <= nx_s1; ny_s2 <= ny_s1;
		n_s2 <= 64'(nx_s1) * 64'(nx_s1) + 64'(ny_s1) * 64'(ny_s1);
	end

	// restoring square root, one result bit per stage
	logic        sv [SQ+1];
	logic        sok [SQ+1];
	logic        ssx [SQ+1];
	logic        ssy [SQ+1];
	logic [30:0] sax [SQ+1];
	logic [30:0] say [SQ+1];
	logic [65:0] rem [SQ+1];
	logic [32:0] root [SQ+1];
	logic [63:0] rad [SQ+1];
	assign sv[0] = v_s2;   assign sok[0] = ok_s2;
	assign ssx[0] = sx_s2; assign ssy[0] = sy_s2;
	assign sax[0] = nx_s2; assign say[0] = ny_s2;
	assign rem[0] = '0;    assign root[0] = '0; assign rad[0] = n_s2;
	for (genvar k = 0; k < SQ; k++) begin : g_sq
		logic [65:0] tr, trial;
		assign tr = {rem[k][63:0], rad[k][63:62]};
		assign trial = {root[k][31:0], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[k+1] <= 1'b0;
			else sv[k+1] <= sv[k];
		end
		always_ff @(posedge clk) begin
			sok[k+1] <= sok[k]; ssx[k+1] <= ssx[k]; ssy[k+1] <= ssy[k];
			sax[k+1] <= sax[k]; say[k+1] <= say[k];
			rad[k+1] <= {rad[k][61:0], 2'b00};
			if (tr >= trial) begin
				rem[k+1] <= tr - trial;
				root[k+1] <= {root[k][31:0], 1'b1};
			end else begin
				rem[k+1] <= tr;
				root[k+1] <= {root[k][31:0], 1'b0};
			end
		end
	end

	// two restoring dividers side by side: (a<<30 + len/2) / len
	logic [31:0] len;
	assign len = root[SQ][31:0];
	logic        dv [DV+1];
	logic        dok [DV+1];
	logic        dsx [DV+1];
	logic        dsy [DV+1];
	logic [31:0] dl [DV+1];
	logic [62:0] numx [DV+1];
	logic [62:0] numy [DV+1];
	logic [32:0] rx [DV+1];
	logic [32:0] ry [DV+1];
	logic [31:0] qx [DV+1];
	logic [31:0] qy [DV+1];
	assign dv[0] = sv[SQ];   assign dok[0] = sok[SQ];
	assign dsx[0] = ssx[SQ]; assign dsy[0] = ssy[SQ];
	assign dl[0] = len;
	assign numx[0] = (63'(sax[SQ]) << UNIT_FRAC) + 63'(len >> 1);
	assign numy[0] = (63'(say[SQ]) << UNIT_FRAC) + 63'(len >> 1);
	assign rx[0] = '0; assign ry[0] = '0; assign qx[0] = '0; assign qy[0] = '0;
	// quotient fits in 32 bits; numerator high bits fold into the first step
	for (genvar k = 0; k < DV; k++) begin : g_dv
		logic [63:0] tx, ty;
		assign tx = (k == 0) ? ({1'b0, numx[0][62:0]} >> 31)
			: 64'({rx[k][31:0], numx[k][31]});
		assign ty = (k == 0) ? ({1'b0, numy[0][62:0]} >> 31)
			: 64'({ry[k][31:0], numy[k][31]});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[k+1] <= 1'b0;
			else dv[k+1] <= dv[k];
		end
		always_ff @(posedge clk) begin
			dok[k+1] <= dok[k]; dsx[k+1] <= dsx[k]; dsy[k+1] <= dsy[k];
			dl[k+1] <= dl[k];
			numx[k+1] <= {numx[k][61:0], 1'b0};
			numy[k+1] <= {numy[k][61:0], 1'b0};
			if (tx >= 64'(dl[k])) begin
				rx[k+1] <= 33'(tx - 64'(dl[k])); qx[k+1] <= {qx[k][30:0], 1'b1};
			end else begin
				rx[k+1] <= 33'(tx); qx[k+1] <= {qx[k][30:0], 1'b0};
			end
			if (ty >= 64'(dl[k])) begin
				ry[k+1] <= 33'(ty - 64'(dl[k])); qy[k+1] <= {qy[k][30:0], 1'b1};
			end else begin
				ry[k+1] <= 33'(ty); qy[k+1] <= {qy[k][30:0], 1'b0};
			end
		end
	end

	assign out_valid = dv[DV];
	assign out_u.ok = dok[DV];
	assign out_u.ux = dsx[DV] ? -$signed({1'b0, qx[DV]}) : $signed({1'b0, qx[DV]});
	assign out_u.uy = dsy[DV] ? -$signed({1'b0, qy[DV]}) : $signed({1'b0, qy[DV]});
endmodule
`default_nettype wire

FILE: src/bend_corner_relief_polygon.sv
// bend_corner_relief_polygon: top level, lanes, merge, direction units, vertex sequencer
// depends on bcrp_pkg, bcrp_lane, bcrp_unit
`timescale 1ns / 1ps
`default_nettype none
// usage
// - a pair of bend lines is taken at a clock edge with start high and busy low
// - four lanes test the endpoint pairs A-A, A-B, B-A, B-B at once; a merge
//   stage picks the first hit and its corner
// - two direction units (normalize, 32-step square root, 32-step divides)
//   run in a pipeline, one vector each per cycle
// - results leave one vertex a cycle on vertex_*, each shown for one cycle with out_valid
//   high; last_vertex marks the final vertex, the receiver cannot stall
// - a pair passes the lane registers, the merge register, the direction units,
//   the offset registers and the vertex registers before its first vertex leaves
// - a new pair is not taken while busy; busy is high after each accept until the
//   pacing counter runs down, so that a full octagon never overlaps the next polygon
// - pairs with no corner or a short direction give no beat at all
// - reset clears the pipeline valids and loads mode dogbone, radius 1.0 mm
// - configuration is written through cfg_valid/cfg_ready, always ready
module bend_corner_relief_polygon import bcrp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] first_a_x,
	input  wire logic signed [31:0] first_a_y,
	input  wire logic signed [31:0] first_b_x,
	input  wire logic signed [31:0] first_b_y,
	input  wire logic signed [31:0] second_a_x,
	input  wire logic signed [31:0] second_a_y,
	input  wire logic signed [31:0] second_b_x,
	input  wire logic signed [31:0] second_b_y,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [30:0]        cfg_data,
	output logic                    out_valid,
	output logic signed [31:0]      vertex_x,
	output logic signed [31:0]      vertex_y,
	output logic [2:0]              vertex_number,
	output logic                    last_vertex
);
	// configuration registers
	logic        mode_q;
	logic [30:0] radius_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DOGBONE;
			radius_q <= 31'd65536;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MODE:   mode_q <= cfg_data[0];
				CFG_RADIUS: radius_q <= cfg_data;
				default:    mode_q <= mode_q;
			endcase
		end
	end

	// input pacing: start is taken only while the gap counter is zero
	logic [2:0] gap_q;
	logic       acc;
	assign busy = (gap_q != 3'd0);
	assign acc = start && !busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gap_q <= '0;
		else if (acc) gap_q <= 3'd7;
		else if (busy) gap_q <= gap_q - 3'd1;
	end

	// endpoint lanes
	logic [3:0] hit_s1;
	bcrp_lane u_l0 (.clk, .p_x(first_a_x), .p_y(first_a_y),
		.q_x(second_a_x), .q_y(second_a_y), .hit_s1(hit_s1[0]));
	bcrp_lane u_l1 (.clk, .p_x(first_a_x), .p_y(first_a_y),
		.q_x(second_b_x), .q_y(second_b_y), .hit_s1(hit_s1[1]));
	bcrp_lane u_l2 (.clk, .p_x(first_b_x), .p_y(first_b_y),
		.q_x(second_a_x), .q_y(second_a_y), .hit_s1(hit_s1[2]));
	bcrp_lane u_l3 (.clk, .p_x(first_b_x), .p_y(first_b_y),
		.q_x(second_b_x), .q_y(second_b_y), .hit_s1(hit_s1[3]));

	logic v_s1;
	logic signed [31:0] fa_x_s1, fa_y_s1, fb_x_s1, fb_y_s1;
	logic signed [31:0] sa_x_s1, sa_y_s1, sb_x_s1, sb_y_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= acc;
	end
	always_ff @(posedge clk) begin
		fa_x_s1 <= first_a_x;  fa_y_s1 <= first_a_y;
		fb_x_s1 <= first_b_x;  fb_y_s1 <= first_b_y;
		sa_x_s1 <= second_a_x; sa_y_s1 <= second_a_y;
		sb_x_s1 <= second_b_x; sb_y_s1 <= second_b_y;
	end

	// merge: first hit wins, pick corner and the two far endpoints
	match_t m;
	logic signed [31:0] cx, cy, f1x, f1y, f2x, f2y;
	always_comb begin
		m.valid = v_s1;
		m.hit = |hit_s1;
		m.sel = hit_s1[0] ? 2'd0 : hit_s1[1] ? 2'd1 : hit_s1[2] ? 2'd2 : 2'd3;
		// corner on the first bend, its other end, and the second bend's far end
		cx  = m.sel[1] ? fb_x_s1 : fa_x_s1;
		cy  = m.sel[1] ? fb_y_s1 : fa_y_s1;
		f1x = m.sel[1] ? fa_x_s1 : fb_x_s1;
		f1y = m.sel[1] ? fa_y_s1 : fb_y_s1;
		f2x = m.sel[0] ? sa_x_s1 : sb_x_s1;
		f2y = m.sel[0] ? sa_y_s1 : sb_y_s1;
	end

	logic s_s2;
	logic signed [32:0] d1x_s2, d1y_s2, d2x_s2, d2y_s2;
	logic signed [31:0] cx_s2, cy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s_s2 <= 1'b0;
		else s_s2 <= m.valid && m.hit;
	end
	always_ff @(posedge clk) begin
		d1x_s2 <= 33'(f1x) - 33'(cx); d1y_s2 <= 33'(f1y) - 33'(cy);
		d2x_s2 <= 33'(f2x) - 33'(cx); d2y_s2 <= 33'(f2y) - 33'(cy);
		cx_s2 <= cx; cy_s2 <= cy;
	end

	// direction units and the matching corner delay line
	unit_t u1, u2;
	logic uv1, uv2;
	bcrp_unit u_dir1 (.clk, .arst_n, .in_valid(s_s2), .dx(d1x_s2), .dy(d1y_s2),
		.out_valid(uv1), .out_u(u1));
	bcrp_unit u_dir2 (.clk, .arst_n, .in_valid(s_s2), .dx(d2x_s2), .dy(d2y_s2),
		.out_valid(uv2), .out_u(u2));

	localparam int UL = UNIT_LATENCY;
	logic [63:0] cdl_q [UL];
	always_ff @(posedge clk) begin
		cdl_q[0] <= {cx_s2, cy_s2};
		for (int i = 1; i < UL; i++) cdl_q[i] <= cdl_q[i-1];
	end

	// offsets: |u|*r rounded, one multiplier per component
	logic go;
	assign go = uv1 && u1.ok && u2.ok;
	logic v_s3;
	logic [63:0] p1x_s3, p1y_s3, p2x_s3, p2y_s3, pd_s3;
	logic n1x_s3, n1y_s3, n2x_s3, n2y_s3;
	logic signed [31:0] cx_s3, cy_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= go;
	end
	always_ff @(posedge clk) begin
		p1x_s3 <= 64'(mag33(u1.ux)) * 64'(radius_q);
		p1y_s3 <= 64'(mag33(u1.uy)) * 64'(radius_q);
		p2x_s3 <= 64'(mag33(u2.ux)) * 64'(radius_q);
		p2y_s3 <= 64'(mag33(u2.uy)) * 64'(radius_q);
		pd_s3  <= 64'(radius_q) * 64'(DIAG_Q32);
		n1x_s3 <= u1.ux[32]; n1y_s3 <= u1.uy[32];
		n2x_s3 <= u2.ux[32]; n2y_s3 <= u2.uy[32];
		cx_s3 <= cdl_q[UL-1][63:32]; cy_s3 <= cdl_q[UL-1][31:0];
	end

	logic [33:0] m1x, m1y, m2x, m2y, md;
	assign m1x = 34'((p1x_s3 + (64'd1 << (UNIT_FRAC-1))) >> UNIT_FRAC);
	assign m1y = 34'((p1y_s3 + (64'd1 << (UNIT_FRAC-1))) >> UNIT_FRAC);
	assign m2x = 34'((p2x_s3 + (64'd1 << (UNIT_FRAC-1))) >> UNIT_FRAC);
	assign m2y = 34'((p2y_s3 + (64'd1 << (UNIT_FRAC-1))) >> UNIT_FRAC);
	assign md  = 34'((pd_s3 + 64'h80000000) >> 32);

	// the eight vertex registers, loaded at once, read out one a cycle by the vertex counter
	logic signed [34:0] o1x, o1y, o2x, o2y, a, d, ccx, ccy;
	logic [31:0] vx [8];
	logic [31:0] vy [8];
	always_comb begin
		o1x = n1x_s3 ? -35'(m1x) : 35'(m1x);
		o1y = n1y_s3 ? -35'(m1y) : 35'(m1y);
		o2x = n2x_s3 ? -35'(m2x) : 35'(m2x);
		o2y = n2y_s3 ? -35'(m2y) : 35'(m2y);
		a = 35'(radius_q);
		d = 35'(md);
		ccx = 35'(cx_s3);
		ccy = 35'(cy_s3);
		if (mode_q == MODE_DOGBONE) begin
			vx[0] = sat32(ccx);             vy[0] = sat32(ccy);
			vx[1] = sat32(ccx + o1x);       vy[1] = sat32(ccy + o1y);
			vx[2] = sat32(ccx + o1x + o2x); vy[2] = sat32(ccy + o1y + o2y);
			vx[3] = sat32(ccx + o2x);       vy[3] = sat32(ccy + o2y);
			for (int i = 4; i < 8; i++) begin
				vx[i] = '0; vy[i] = '0;
			end
		end else begin
			vx[0] = sat32(ccx + a); vy[0] = sat32(ccy);
			vx[1] = sat32(ccx + d); vy[1] = sat32(ccy - d);
			vx[2] = sat32(ccx);     vy[2] = sat32(ccy - a);
			vx[3] = sat32(ccx - d); vy[3] = sat32(ccy - d);
			vx[4] = sat32(ccx - a); vy[4] = sat32(ccy);
			vx[5] = sat32(ccx - d); vy[5] = sat32(ccy + d);
			vx[6] = sat32(ccx);     vy[6] = sat32(ccy + a);
			vx[7] = sat32(ccx + d); vy[7] = sat32(ccy + d);
		end
	end

	logic [31:0] bx_q [8];
	logic [31:0] by_q [8];
	logic [2:0]  cnt_q, lastn_q;
	logic        act_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
			lastn_q <= '0;
		end else if (v_s3) begin
			act_q <= 1'b1;
			cnt_q <= '0;
			lastn_q <= (mode_q == MODE_DOGBONE) ? 3'd3 : 3'd7;
		end else if (act_q) begin
			if (cnt_q == lastn_q) act_q <= 1'b0;
			cnt_q <= cnt_q + 3'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (v_s3) begin
			for (int i = 0; i < 8; i++) begin
				bx_q[i] <= vx[i]; by_q[i] <= vy[i];
			end
		end
	end

	assign out_valid = act_q;
	assign vertex_x = bx_q[cnt_q];
	assign vertex_y = by_q[cnt_q];
	assign vertex_number = cnt_q;
	assign last_vertex = (cnt_q == lastn_q);

	a_units_aligned: assert property (@(posedge clk) disable iff (!arst_n) uv1 == uv2)
		else $error("direction units out of step");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_vertex) |=> (!out_valid || vertex_number == 3'd0))
		else $error("beat after last vertex");
	a_num_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_vertex) |=> (out_valid && vertex_number == $past(vertex_number) + 3'd1))
		else $error("vertex sequence broken");
	a_pace: assert property (@(posedge clk) disable iff (!arst_n) acc |=> busy)
		else $error("accept not paced");
endmodule
`default_nettype wire
